// ----- hw/rtl/dedf_pkg.sv -----
// Package: constants, types and helpers shared by the event deframer modules.
package dedf_pkg;

    localparam int MaxBoardsDefault = 16;
    localparam logic [31:0] EvMagic = 32'hfa4af1ca;
    localparam logic [31:0] BdMagic = 32'hbaba1a9a;
    localparam logic [31:0] FtMagic = 32'h0bedface;
    localparam int EvHdrWords = 7;
    localparam int BdHdrWords = 10;
    localparam int SamplesPerBoard = 1792;
    localparam int QueueDepth = 4;

    localparam logic [2:0] ST_OK = 3'd0;
    localparam logic [2:0] ST_BAD_EVENT = 3'd1;
    localparam logic [2:0] ST_SHORT = 3'd2;
    localparam logic [2:0] ST_BAD_BOARD = 3'd3;
    localparam logic [2:0] ST_BAD_FOOTER = 3'd4;
    localparam logic [2:0] ST_CAL_BEAM = 3'd5;
    localparam logic [2:0] ST_BEAM_CAL = 3'd6;

    localparam logic [0:0] REG_NUM_BOARDS = 1'd0;
    localparam logic [0:0] REG_CAL_MODE = 1'd1;

    localparam logic [1:0] OP_NONE = 2'd0;
    localparam logic [1:0] OP_STATUS = 2'd1;
    localparam logic [1:0] OP_PAYLOAD = 2'd2;

    localparam logic [0:0] KIND_SAMPLE = 1'b0;
    localparam logic [0:0] KIND_STATUS = 1'b1;

    // classified work item handed from front to back
    typedef struct packed {
        logic [1:0]  op;
        logic [2:0]  code;
        logic        use_final;
        logic [31:0] word;
        logic [2:0]  pair_slot;
        logic [6:0]  chan;
        logic [4:0]  board;
        logic [31:0] trig_word;
        logic [31:0] event_id;
        logic [31:0] trig_num;
    } work_t;

    typedef struct packed {
        logic        kind;
        logic [4:0]  detector_index;
        logic [9:0]  strip_index;
        logic [13:0] sample_value;
        logic [2:0]  status_code;
        logic [7:0]  trigger_type;
        logic [6:0]  subsystem;
        logic        crc_flag;
        logic [31:0] trigger_event_id;
        logic [31:0] board_trigger_number;
        logic        last;
    } result_t;

    // remapped adc for raw adc slot
    function automatic logic [3:0] adc_map(input logic [3:0] a);
        logic [3:0] r;
        begin
            unique case (a)
                4'd0: r = 4'd12;
                4'd1: r = 4'd13;
                4'd2: r = 4'd10;
                4'd3: r = 4'd11;
                4'd4: r = 4'd8;
                4'd5: r = 4'd9;
                4'd6: r = 4'd6;
                4'd7: r = 4'd7;
                4'd8: r = 4'd4;
                4'd9: r = 4'd5;
                4'd10: r = 4'd2;
                4'd11: r = 4'd3;
                4'd12: r = 4'd0;
                4'd13: r = 4'd1;
                default: r = 4'd0;
            endcase
            adc_map = r;
        end
    endfunction

endpackage

// ----- hw/rtl/dedf_if.sv -----
// Interfaces: word input, result output and configuration write channels.
interface dedf_word_if;
    logic        valid;
    logic        ready;
    logic [31:0] in_word;
    modport source (output valid, output in_word, input ready);
    modport sink (input valid, input in_word, output ready);
endinterface

interface dedf_result_if;
    logic        valid;
    logic        ready;
    logic        result_kind;
    logic [4:0]  detector_index;
    logic [9:0]  strip_index;
    logic [13:0] sample_value;
    logic [2:0]  status_code;
    logic [7:0]  trigger_type;
    logic [6:0]  subsystem;
    logic        crc_flag;
    logic [31:0] trigger_event_id;
    logic [31:0] board_trigger_number;
    logic        last;
    modport source (output valid, output result_kind, output detector_index,
        output strip_index, output sample_value, output status_code,
        output trigger_type, output subsystem, output crc_flag,
        output trigger_event_id, output board_trigger_number, output last,
        input ready);
    modport sink (input valid, input result_kind, input detector_index,
        input strip_index, input sample_value, input status_code,
        input trigger_type, input subsystem, input crc_flag,
        input trigger_event_id, input board_trigger_number, input last,
        output ready);
endinterface

interface dedf_cfg_if;
    logic        valid;
    logic        ready;
    logic [0:0]  index;
    logic [31:0] data;
    modport source (output valid, output index, output data, input ready);
    modport sink (input valid, input index, input data, output ready);
endinterface

// ----- hw/rtl/detector_event_deframer_unit.sv -----
// Top level: detector event deframer with front end, work queue and back end.
// Accepts one stream word per cycle; the framing
// state machine classifies each word, and words that yield a work item go
// into a four-entry queue; input stalls only when the queue fills. The back
// end delivers one result per cycle from an output register while the
// receiver is ready; a payload word gives two results and other items one.
// A word passes through the queue, then the output register, to the output.
module detector_event_deframer_unit #(
    parameter int MAX_BOARDS = dedf_pkg::MaxBoardsDefault
) (
    input logic       clk,
    input logic       rst_n,
    dedf_word_if.sink     in_ch,
    dedf_result_if.source out_ch,
    dedf_cfg_if.sink      cfg
);
    logic [4:0]        board_limit_reg;
    logic              cal_mode_reg;
    dedf_pkg::work_t   fw, qw;
    logic              accept, push, full, empty, take, busy;
    dedf_pkg::result_t res;

    assign in_ch.ready = !full;
    assign accept = in_ch.valid && in_ch.ready;
    assign push = accept && fw.op != dedf_pkg::OP_NONE;
    assign cfg.ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            board_limit_reg <= 5'd1;
            cal_mode_reg <= 1'b0;
        end
        else if (cfg.valid)
        begin
            unique case (cfg.index)
                dedf_pkg::REG_NUM_BOARDS: board_limit_reg <= cfg.data[4:0];
                dedf_pkg::REG_CAL_MODE: cal_mode_reg <= cfg.data[0];
                default: ;
            endcase
        end
    end

    dedf_front #(.MAX_BOARDS(MAX_BOARDS)) u_front (
        .clk(clk), .rst_n(rst_n), .accept(accept), .word(in_ch.in_word),
        .board_limit(board_limit_reg), .work(fw), .busy(busy)
    );

    dedf_queue u_queue (
        .clk(clk), .rst_n(rst_n), .push(push), .push_data(fw), .pop(take),
        .pop_data(qw), .full(full), .empty(empty)
    );

    dedf_back u_back (
        .clk(clk), .rst_n(rst_n), .cal_mode(cal_mode_reg), .have(!empty),
        .work(qw), .take(take), .out_valid(out_ch.valid),
        .out_ready(out_ch.ready), .res(res)
    );

    assign out_ch.result_kind = res.kind;
    assign out_ch.detector_index = res.detector_index;
    assign out_ch.strip_index = res.strip_index;
    assign out_ch.sample_value = res.sample_value;
    assign out_ch.status_code = res.status_code;
    assign out_ch.trigger_type = res.trigger_type;
    assign out_ch.subsystem = res.subsystem;
    assign out_ch.crc_flag = res.crc_flag;
    assign out_ch.trigger_event_id = res.trigger_event_id;
    assign out_ch.board_trigger_number = res.board_trigger_number;
    assign out_ch.last = res.last;

`ifndef ASSERT_OFF
    a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
        full |-> !push) else $error("queue overflow");
    a_no_underflow: assert property (@(posedge clk) disable iff (!rst_n)
        empty |-> !take) else $error("queue underflow");
    a_sample_kind: assert property (@(posedge clk) disable iff (!rst_n)
        out_ch.valid && out_ch.result_kind == dedf_pkg::KIND_SAMPLE
        |-> out_ch.status_code == dedf_pkg::ST_OK) else $error("sample with status");
    a_hunt_status: assert property (@(posedge clk) disable iff (!rst_n)
        accept && !busy && in_ch.in_word != dedf_pkg::EvMagic |-> push)
        else $error("lost bad header status");
`endif
endmodule

// ----- hw/rtl/dedf_front.sv -----
// Front end: framing state machine that classifies each word into a work item.
module dedf_front #(
    parameter int MAX_BOARDS = dedf_pkg::MaxBoardsDefault
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              accept,
    input  logic [31:0]       word,
    input  logic [4:0]        board_limit,
    output dedf_pkg::work_t   work,
    output logic              busy
);
    localparam logic [2:0] PH_HUNT = 3'd0;
    localparam logic [2:0] PH_EVHDR = 3'd1;
    localparam logic [2:0] PH_BHDR = 3'd2;
    localparam logic [2:0] PH_BFIELDS = 3'd3;
    localparam logic [2:0] PH_PAYLOAD = 3'd4;
    localparam logic [2:0] PH_FOOTER = 3'd5;
    localparam logic [2:0] PH_CRC = 3'd6;
    localparam int BW = $clog2(MAX_BOARDS + 1) > 5 ? $clog2(MAX_BOARDS + 1) : 5;

    logic [2:0]  phase_reg, phase_next;
    logic [3:0]  wcnt_reg, wcnt_next;
    logic [BW-1:0] bcnt_reg, bcnt_next;
    logic [2:0]  slot_reg, slot_next;
    logic [6:0]  chan_reg, chan_next;
    logic [31:0] trig_reg, trig_next;
    logic [31:0] evid_reg, evid_next;
    logic [31:0] tnum_reg, tnum_next;
    logic [BW-1:0] expected;
    logic [BW-1:0] bcnt_inc;

    assign busy = phase_reg != PH_HUNT;
    assign bcnt_inc = bcnt_reg + 1'b1;

    always_comb
    begin
        if (BW'(board_limit) > BW'(MAX_BOARDS))
            expected = BW'(MAX_BOARDS);
        else
            expected = BW'(board_limit);
    end

    always_comb
    begin
        phase_next = phase_reg;
        wcnt_next = wcnt_reg;
        bcnt_next = bcnt_reg;
        slot_next = slot_reg;
        chan_next = chan_reg;
        trig_next = trig_reg;
        evid_next = evid_reg;
        tnum_next = tnum_reg;
        work = '0;
        work.word = word;
        work.pair_slot = slot_reg;
        work.chan = chan_reg;
        work.board = bcnt_reg[4:0];
        work.trig_word = trig_reg;
        work.event_id = evid_reg;
        work.trig_num = tnum_reg;
        unique case (phase_reg)
            PH_HUNT:
            begin
                if (word == dedf_pkg::EvMagic)
                begin
                    phase_next = PH_EVHDR;
                    wcnt_next = '0;
                    bcnt_next = '0;
                    slot_next = '0;
                    chan_next = '0;
                    trig_next = 32'h8000_0000;
                    evid_next = '0;
                end
                else
                begin
                    work.op = dedf_pkg::OP_STATUS;
                    work.code = dedf_pkg::ST_BAD_EVENT;
                end
            end
            PH_EVHDR:
            begin
                wcnt_next = wcnt_reg + 1'b1;
                if (wcnt_reg == 4'(dedf_pkg::EvHdrWords - 1))
                begin
                    wcnt_next = '0;
                    if (bcnt_reg < expected)
                        phase_next = PH_BHDR;
                    else
                    begin
                        work.op = dedf_pkg::OP_STATUS;
                        work.use_final = 1'b1;
                        phase_next = PH_HUNT;
                    end
                end
            end
            PH_BHDR:
            begin
                if (word == dedf_pkg::BdMagic)
                begin
                    phase_next = PH_BFIELDS;
                    wcnt_next = '0;
                end
                else if (word == dedf_pkg::EvMagic)
                begin
                    work.op = dedf_pkg::OP_STATUS;
                    work.code = dedf_pkg::ST_SHORT;
                    phase_next = PH_EVHDR;
                    wcnt_next = '0;
                    bcnt_next = '0;
                    slot_next = '0;
                    chan_next = '0;
                    trig_next = 32'h8000_0000;
                    evid_next = '0;
                end
                else
                begin
                    work.op = dedf_pkg::OP_STATUS;
                    work.code = dedf_pkg::ST_BAD_BOARD;
                    phase_next = PH_HUNT;
                end
            end
            PH_BFIELDS:
            begin
                if (wcnt_reg == 4'd2)
                    tnum_next = word;
                else if (wcnt_reg == 4'd4 && bcnt_reg == '0)
                    evid_next = word;
                else if (wcnt_reg == 4'd5 && bcnt_reg == '0)
                    trig_next = word;
                wcnt_next = wcnt_reg + 1'b1;
                if (wcnt_reg == 4'(dedf_pkg::BdHdrWords - 1))
                begin
                    wcnt_next = '0;
                    slot_next = '0;
                    chan_next = '0;
                    phase_next = PH_PAYLOAD;
                end
            end
            PH_PAYLOAD:
            begin
                work.op = dedf_pkg::OP_PAYLOAD;
                // advance the adc pair slot, then the channel after seven pairs
                if (slot_reg == 3'd6)
                begin
                    slot_next = '0;
                    chan_next = chan_reg + 7'd1;
                end
                else
                    slot_next = slot_reg + 3'd1;
                if (slot_reg == 3'd6 && chan_reg == 7'(dedf_pkg::SamplesPerBoard / 14 - 1))
                begin
                    slot_next = '0;
                    chan_next = '0;
                    phase_next = PH_FOOTER;
                end
            end
            PH_FOOTER:
            begin
                if (word != dedf_pkg::FtMagic)
                begin
                    work.op = dedf_pkg::OP_STATUS;
                    work.code = dedf_pkg::ST_BAD_FOOTER;
                    phase_next = PH_HUNT;
                end
                else
                    phase_next = PH_CRC;
            end
            PH_CRC:
            begin
                bcnt_next = bcnt_inc;
                if (bcnt_inc < expected)
                    phase_next = PH_BHDR;
                else
                begin
                    work.op = dedf_pkg::OP_STATUS;
                    work.use_final = 1'b1;
                    phase_next = PH_HUNT;
                end
            end
            default:
                phase_next = PH_HUNT;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= PH_HUNT;
            wcnt_reg <= '0;
            bcnt_reg <= '0;
            slot_reg <= '0;
            chan_reg <= '0;
            trig_reg <= '0;
            evid_reg <= '0;
            tnum_reg <= '0;
        end
        else if (accept)
        begin
            phase_reg <= phase_next;
            wcnt_reg <= wcnt_next;
            bcnt_reg <= bcnt_next;
            slot_reg <= slot_next;
            chan_reg <= chan_next;
            trig_reg <= trig_next;
            evid_reg <= evid_next;
            tnum_reg <= tnum_next;
        end
    end
endmodule

// ----- hw/rtl/dedf_queue.sv -----
// Work queue: small FIFO between the front end and the back end.
module dedf_queue (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            push,
    input  dedf_pkg::work_t push_data,
    input  logic            pop,
    output dedf_pkg::work_t pop_data,
    output logic            full,
    output logic            empty
);
    localparam int AW = $clog2(dedf_pkg::QueueDepth);

    dedf_pkg::work_t mem [dedf_pkg::QueueDepth];
    logic [AW-1:0] wptr_reg, rptr_reg;
    logic [AW:0]   cnt_reg;

    assign full = cnt_reg == (AW + 1)'(dedf_pkg::QueueDepth);
    assign empty = cnt_reg == '0;
    assign pop_data = mem[rptr_reg];

    always_ff @(posedge clk)
    begin
        if (push)
            mem[wptr_reg] <= push_data;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wptr_reg <= '0;
            rptr_reg <= '0;
            cnt_reg <= '0;
        end
        else
        begin
            if (push)
                wptr_reg <= wptr_reg + 1'b1;
            if (pop)
                rptr_reg <= rptr_reg + 1'b1;
            cnt_reg <= cnt_reg + (AW + 1)'(push) - (AW + 1)'(pop);
        end
    end
endmodule

// ----- hw/rtl/dedf_back.sv -----
// Back end: expands work items into sample and status results with an output register.
module dedf_back (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              cal_mode,
    input  logic              have,
    input  dedf_pkg::work_t   work,
    output logic              take,
    output logic              out_valid,
    input  logic              out_ready,
    output dedf_pkg::result_t res
);
    logic              valid_reg;
    dedf_pkg::result_t res_reg;
    logic              half_reg, half_next;
    logic              load;
    dedf_pkg::result_t r;
    logic [15:0]       raw;
    logic [3:0]        adc_raw, adc;
    logic [6:0]        ch_raw, ch;
    logic              side;
    logic [2:0]        adc_loc;
    logic [7:0]        tt;
    logic [6:0]        ss;
    logic [2:0]        fcode;

    assign load = have && (!valid_reg || out_ready);
    assign out_valid = valid_reg;
    assign res = res_reg;
    assign take = load && (work.op != dedf_pkg::OP_PAYLOAD || half_reg);

    always_comb
    begin
        raw = half_reg ? work.word[31:16] : work.word[15:0];
        adc_raw = {work.pair_slot, half_reg};
        ch_raw = work.chan;
        ch = ch_raw[0] ? ch_raw - 7'd1 : ch_raw + 7'd1;
        adc = dedf_pkg::adc_map(adc_raw);
        side = adc < 4'd7;
        adc_loc = side ? adc[2:0] : 3'(adc - 4'd7);
        tt = work.trig_word[7:0];
        ss = work.trig_word[22:16];
        if (tt == '0 && ss == '0 && !work.trig_word[31] && work.event_id == '0)
            fcode = dedf_pkg::ST_OK;
        else if (ss != 7'h0a && ss != 7'h0b)
            fcode = dedf_pkg::ST_OK;
        else if (cal_mode && tt[0])
            fcode = dedf_pkg::ST_CAL_BEAM;
        else if (!cal_mode && !tt[0])
            fcode = dedf_pkg::ST_BEAM_CAL;
        else
            fcode = dedf_pkg::ST_OK;
        r = '0;
        if (work.op == dedf_pkg::OP_PAYLOAD)
        begin
            r.kind = dedf_pkg::KIND_SAMPLE;
            r.detector_index = {work.board[3:0], side};
            r.strip_index = {adc_loc, ch};
            r.sample_value = raw[15:2];
            r.last = half_reg;
        end
        else
        begin
            r.kind = dedf_pkg::KIND_STATUS;
            r.status_code = work.use_final ? fcode : work.code;
            r.trigger_type = tt;
            r.subsystem = ss;
            r.crc_flag = work.trig_word[31];
            r.trigger_event_id = work.event_id;
            r.board_trigger_number = work.trig_num;
            r.last = 1'b1;
        end
        half_next = half_reg;
        if (load && work.op == dedf_pkg::OP_PAYLOAD)
            half_next = !half_reg;
    end

    always_ff @(posedge clk)
    begin
        if (load)
            res_reg <= r;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
            half_reg <= 1'b0;
        end
        else
        begin
            half_reg <= half_next;
            if (load)
                valid_reg <= 1'b1;
            else if (out_ready)
                valid_reg <= 1'b0;
        end
    end
endmodule

// ----- tb/sv/dedf_tb_pkg.sv -----
`timescale 1ns / 1ps
// Testbench package: event deframer prediction and result scoreboard class.
package dedf_tb_pkg;
    import dedf_pkg::*;

    typedef enum logic [2:0] {
        FR_HUNT, FR_EVHDR, FR_BHDR, FR_BFIELDS, FR_PAYLOAD, FR_FOOTER, FR_CRC
    } frame_phase_t;

    class deframe_scoreboard;
        logic [4:0]   boards_cfg;
        logic         cal_run;
        frame_phase_t fphase;
        int unsigned  wcount;
        int unsigned  bcount;
        int unsigned  scount;
        logic [31:0]  trig_word;
        logic [31:0]  event_id;
        logic [31:0]  trig_num;
        result_t      pending[$];
        int unsigned  mismatches;

        function new();
            boards_cfg = 5'd1;
            cal_run = 1'b0;
            fphase = FR_HUNT;
            wcount = 0;
            bcount = 0;
            scount = 0;
            trig_word = '0;
            event_id = '0;
            trig_num = '0;
            mismatches = 0;
        endfunction

        function void write_reg(logic [0:0] idx, logic [31:0] data);
            if (idx == REG_NUM_BOARDS)
                boards_cfg = data[4:0];
            else
                cal_run = data[0];
        endfunction

        function int unsigned boards_due();
            return (boards_cfg > MaxBoardsDefault) ? MaxBoardsDefault : boards_cfg;
        endfunction

        function void begin_event();
            fphase = FR_EVHDR;
            wcount = 0;
            bcount = 0;
            scount = 0;
            trig_word = 32'h8000_0000;
            event_id = '0;
        endfunction

        function void push_status(logic [2:0] code);
            result_t r;
            r = '0;
            r.kind = KIND_STATUS;
            r.status_code = code;
            r.trigger_type = trig_word[7:0];
            r.subsystem = trig_word[22:16];
            r.crc_flag = trig_word[31];
            r.trigger_event_id = event_id;
            r.board_trigger_number = trig_num;
            r.last = 1'b1;
            pending.insert(pending.size(), r);
        endfunction

        function void push_sample(int unsigned idx, logic [15:0] raw, logic lst);
            result_t r;
            int unsigned adc;
            int unsigned ch;
            int unsigned chr;
            adc = 13 - (idx % 14) + (((idx % 14) % 2 == 1) ? 1 : -1) * 1;
            adc = (idx % 14 % 2 == 1) ? 14 - (idx % 14) : 12 - (idx % 14);
            chr = idx / 14;
            ch = chr[0] ? chr - 1 : chr + 1;
            r = '0;
            r.kind = KIND_SAMPLE;
            r.detector_index = 5'((2 * bcount + (1 - adc / 7)));
            r.strip_index = 10'(((adc % 7) * 128 + ch));
            r.sample_value = raw[15:2];
            r.last = lst;
            pending.insert(pending.size(), r);
        endfunction

        function logic [2:0] closing_code();
            if (trig_word[7:0] == 0 && trig_word[22:16] == 0 && !trig_word[31] && event_id == 0)
                return ST_OK;
            if (trig_word[22:16] != 7'h0a && trig_word[22:16] != 7'h0b)
                return ST_OK;
            if (cal_run && trig_word[0])
                return ST_CAL_BEAM;
            if (!cal_run && !trig_word[0])
                return ST_BEAM_CAL;
            return ST_OK;
        endfunction

        function void note_word(logic [31:0] w);
            case (fphase)
                FR_HUNT:
                    if (w == EvMagic) begin_event();
                    else push_status(ST_BAD_EVENT);
                FR_EVHDR:
                begin
                    wcount++;
                    if (wcount >= EvHdrWords)
                    begin
                        wcount = 0;
                        if (bcount < boards_due())
                            fphase = FR_BHDR;
                        else
                        begin
                            push_status(closing_code());
                            fphase = FR_HUNT;
                        end
                    end
                end
                FR_BHDR:
                    if (w == BdMagic)
                    begin
                        fphase = FR_BFIELDS;
                        wcount = 0;
                    end
                    else if (w == EvMagic)
                    begin
                        push_status(ST_SHORT);
                        begin_event();
                    end
                    else
                    begin
                        push_status(ST_BAD_BOARD);
                        fphase = FR_HUNT;
                    end
                FR_BFIELDS:
                begin
                    if (wcount == 2)
                        trig_num = w;
                    else if (wcount == 4 && bcount == 0)
                        event_id = w;
                    else if (wcount == 5 && bcount == 0)
                        trig_word = w;
                    wcount++;
                    if (wcount >= BdHdrWords)
                    begin
                        wcount = 0;
                        scount = 0;
                        fphase = FR_PAYLOAD;
                    end
                end
                FR_PAYLOAD:
                begin
                    push_sample(scount, w[15:0], 1'b0);
                    push_sample(scount + 1, w[31:16], 1'b1);
                    scount += 2;
                    if (scount >= SamplesPerBoard)
                    begin
                        scount = 0;
                        fphase = FR_FOOTER;
                    end
                end
                FR_FOOTER:
                    if (w != FtMagic)
                    begin
                        push_status(ST_BAD_FOOTER);
                        fphase = FR_HUNT;
                    end
                    else
                        fphase = FR_CRC;
                default:
                begin
                    bcount++;
                    if (bcount < boards_due())
                        fphase = FR_BHDR;
                    else
                    begin
                        push_status(closing_code());
                        fphase = FR_HUNT;
                    end
                end
            endcase
        endfunction

        function void check_result(result_t got);
            result_t exp;
            if (pending.size() == 0)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected result %h", got);
                return;
            end
            exp = pending.pop_front();
            if (got !== exp)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display("mismatch: expected %h actual %h", exp, got);
            end
        endfunction
    endclass
endpackage

// ----- tb/sv/detector_event_deframer_unit_tb.sv -----
`timescale 1ns / 1ps
// Top testbench: drives words and register writes, checks every result.
module detector_event_deframer_unit_tb;
    import dedf_pkg::*;
    import dedf_tb_pkg::*;

    logic clk;
    logic rst_n;
    dedf_word_if   word_ch ();
    dedf_result_if res_ch ();
    dedf_cfg_if    cfg_ch ();

    deframe_scoreboard board_sb;
    int unsigned idle_cycles;
    int unsigned hold_req;
    bit          quiet_sink;

    detector_event_deframer_unit uut (
        .clk   (clk),
        .rst_n (rst_n),
        .in_ch (word_ch.sink),
        .out_ch(res_ch.source),
        .cfg   (cfg_ch.sink)
    );

    initial
    begin
        clk = 1'b0;
        forever #10 clk = ~clk;
    end

    initial
    begin
        board_sb = new();
        rst_n = 1'b0;
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
    end

    always @(posedge clk)
    begin
        if (rst_n && word_ch.valid && word_ch.ready)
            board_sb.note_word(word_ch.in_word);
        if (rst_n && res_ch.valid && res_ch.ready)
        begin
            result_t r;
            r.kind = res_ch.result_kind;
            r.detector_index = res_ch.detector_index;
            r.strip_index = res_ch.strip_index;
            r.sample_value = res_ch.sample_value;
            r.status_code = res_ch.status_code;
            r.trigger_type = res_ch.trigger_type;
            r.subsystem = res_ch.subsystem;
            r.crc_flag = res_ch.crc_flag;
            r.trigger_event_id = res_ch.trigger_event_id;
            r.board_trigger_number = res_ch.board_trigger_number;
            r.last = res_ch.last;
            board_sb.check_result(r);
        end
    end

    always @(posedge clk)
    begin
        if ((word_ch.valid && word_ch.ready) || (res_ch.valid && res_ch.ready)
            || (cfg_ch.valid && cfg_ch.ready) || !rst_n)
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles > 2000)
        begin
            $display("simulation failed");
            $finish;
        end
    end

    // receiver: random stalls, or a long hold-off when asked
    initial
    begin
        int unsigned wait_n;
        int unsigned hold_done;
        res_ch.ready = 1'b0;
        hold_done = 0;
        @(posedge rst_n);
        forever
        begin
            if (hold_req != hold_done)
            begin
                res_ch.ready <= 1'b0;
                repeat (300) @(posedge clk);
                hold_done = hold_req;
            end
            wait_n = quiet_sink ? 0 : (($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 17));
            if ($urandom_range(0, 2) == 0) wait_n = 0;
            if (wait_n > 0)
            begin
                res_ch.ready <= 1'b0;
                repeat (wait_n) @(posedge clk);
            end
            res_ch.ready <= 1'b1;
            @(posedge clk);
            while (!res_ch.valid && hold_req == hold_done) @(posedge clk);
        end
    end

    task automatic send_word(logic [31:0] w, bit busy);
        int unsigned gap;
        gap = busy ? 0 : (($urandom_range(0, 3) == 0) ? $urandom_range(0, 17) : 0);
        if (gap > 0)
        begin
            word_ch.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        word_ch.valid <= 1'b1;
        word_ch.in_word <= w;
        @(posedge clk);
        while (!word_ch.ready) @(posedge clk);
    endtask

    task automatic drain();
        word_ch.valid <= 1'b0;
        @(posedge clk);
        while (board_sb.pending.size() != 0) @(posedge clk);
        repeat (8) @(posedge clk);
    endtask

    task automatic write_reg(logic [0:0] idx, logic [31:0] data);
        drain();
        cfg_ch.valid <= 1'b1;
        cfg_ch.index <= idx;
        cfg_ch.data <= data;
        @(posedge clk);
        while (!cfg_ch.ready) @(posedge clk);
        board_sb.write_reg(idx, data);
        cfg_ch.valid <= 1'b0;
    endtask

    function automatic logic [31:0] rand_trig();
        logic [31:0] t;
        t = $urandom;
        if ($urandom_range(0, 3) != 0)
            t[22:16] = $urandom_range(0, 1) ? 7'h0a : 7'h0b;
        return t;
    endfunction

    // one event; fault 0 clean, 1 bad board header, 2 short, 3 bad footer
    task automatic send_event(int unsigned boards, int unsigned fault, bit busy);
        send_word(EvMagic, busy);
        for (int i = 0; i < EvHdrWords; i++) send_word($urandom, busy);
        for (int b = 0; b < boards; b++)
        begin
            if (fault == 1 && b == boards - 1)
            begin
                send_word($urandom_range(0, 1) ? 32'hbaba1a9b : $urandom, busy);
                return;
            end
            if (fault == 2 && b == boards - 1)
            begin
                send_word(EvMagic, busy);
                return;
            end
            send_word(BdMagic, busy);
            for (int i = 0; i < BdHdrWords; i++)
                send_word(i == 5 ? rand_trig() : $urandom, busy);
            for (int i = 0; i < SamplesPerBoard / 2; i++)
                send_word($urandom, busy);
            if (fault == 3 && b == boards - 1)
            begin
                send_word(FtMagic ^ (32'h1 << $urandom_range(0, 31)), busy);
                return;
            end
            send_word(FtMagic, busy);
            send_word($urandom, busy);
        end
    endtask

    initial
    begin
        word_ch.valid = 1'b0;
        word_ch.in_word = '0;
        cfg_ch.valid = 1'b0;
        cfg_ch.index = REG_NUM_BOARDS;
        cfg_ch.data = '0;
        @(posedge rst_n);
        @(posedge clk);
        send_word(32'h0000_0000, 1'b0);
        send_word(32'hffff_ffff, 1'b0);
        send_event(1, 1, 1'b0);
        send_event(1, 2, 1'b0);
        send_word($urandom, 1'b0);
        write_reg(REG_NUM_BOARDS, 32'd0);
        send_event(0, 0, 1'b0);
        send_word(32'hffff_ffff, 1'b0);
        write_reg(REG_CAL_MODE, 32'd1);
        write_reg(REG_NUM_BOARDS, 32'd31);
        send_event(1, 2, 1'b0);
        // finish the restarted header, then drop back to hunting
        for (int i = 0; i < 8; i++) send_word($urandom, 1'b0);
        write_reg(REG_NUM_BOARDS, 32'd1);
        hold_req++;
        send_event(1, 0, 1'b1);
        for (int ph = 0; ph < 4; ph++)
        begin
            write_reg(REG_NUM_BOARDS, ph == 3 ? 32'd16 : 32'($urandom_range(0, 3)));
            write_reg(REG_CAL_MODE, 32'(ph[0]));
            quiet_sink = (ph == 2);
            for (int e = 0; e < 4; e++)
            begin
                if ($urandom_range(0, 2) == 0)
                    send_word($urandom, e[0]);
                else
                    send_event(board_sb.boards_due() > 0 ? 1 : 0,
                        board_sb.boards_due() > 0 ? $urandom_range(1, 2) : 0, e[0]);
            end
        end
        drain();
        repeat (20) @(posedge clk);
        if (board_sb.mismatches == 0 && board_sb.pending.size() == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end
endmodule
